>>> hw/rtl/pn_pkg.sv
// ---------------------------------------------------------------------------
// pn_pkg
// Shared widths, codes, types and the sigmoid table of the perceptron neuron.
// ---------------------------------------------------------------------------
package pn_pkg;

	localparam int W_IDX        = 4;
	localparam int W_VAL        = 16;
	localparam int W_PROD       = 2 * W_VAL;
	localparam int W_ACC        = 40;
	localparam int W_MODE       = 2;
	localparam int FRAC_BITS    = 8;
	localparam int MAX_TAPS_DEF = 16;
	localparam int OFIFO_DEPTH  = 8;

	// Opcodes of an input beat.
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Activation modes; the unused code behaves as the raw sum.
	localparam logic [W_MODE-1:0] MODE_RAW     = 2'd0;
	localparam logic [W_MODE-1:0] MODE_STEP    = 2'd1;
	localparam logic [W_MODE-1:0] MODE_SIGMOID = 2'd2;

	// Control travelling with a sample down the pipeline.
	typedef struct packed {
		logic vld;   // stage holds a sample
		logic en;    // sample lies within the weight range
		logic last;  // final sample of the vector
	} smp_ctl_t;

	// One result beat.
	typedef struct packed {
		logic signed [W_VAL-1:0] act;
		logic                    sat;
	} res_t;

	// Upper half of the logistic curve in Q8.8, for Q4.4 arguments 0 to 128.
	localparam logic [8:0] SIG_HALF [0:128] = '{
		9'd128, 9'd132, 9'd136, 9'd140, 9'd144, 9'd148, 9'd152, 9'd156,
		9'd159, 9'd163, 9'd167, 9'd170, 9'd174, 9'd177, 9'd181, 9'd184,
		9'd187, 9'd190, 9'd193, 9'd196, 9'd199, 9'd202, 9'd204, 9'd207,
		9'd209, 9'd212, 9'd214, 9'd216, 9'd218, 9'd220, 9'd222, 9'd224,
		9'd225, 9'd227, 9'd229, 9'd230, 9'd232, 9'd233, 9'd234, 9'd235,
		9'd237, 9'd238, 9'd239, 9'd240, 9'd241, 9'd241, 9'd242, 9'd243,
		9'd244, 9'd245, 9'd245, 9'd246, 9'd246, 9'd247, 9'd248, 9'd248,
		9'd248, 9'd249, 9'd249, 9'd250, 9'd250, 9'd250, 9'd251, 9'd251,
		9'd251, 9'd252, 9'd252, 9'd252, 9'd252, 9'd253, 9'd253, 9'd253,
		9'd253, 9'd253, 9'd254, 9'd254, 9'd254, 9'd254, 9'd254, 9'd254,
		9'd254, 9'd254, 9'd254, 9'd255, 9'd255, 9'd255, 9'd255, 9'd255,
		9'd255, 9'd255, 9'd255, 9'd255, 9'd255, 9'd255, 9'd255, 9'd255,
		9'd255, 9'd255, 9'd255, 9'd255, 9'd256, 9'd256, 9'd256, 9'd256,
		9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256,
		9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256,
		9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256,
		9'd256
	};

endpackage

>>> hw/rtl/pn_wstore.sv
// ---------------------------------------------------------------------------
// pn_wstore
// Weight memory with one write and one registered read port, plus bias copy.
// ---------------------------------------------------------------------------
module pn_wstore #(
	parameter int MAX_TAPS = pn_pkg::MAX_TAPS_DEF,
	parameter int AW       = $clog2(MAX_TAPS)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [pn_pkg::W_IDX-1:0]       wr_idx,
	input  logic signed [pn_pkg::W_VAL-1:0] wr_data,
	input  logic                           rd_en,
	input  logic [AW-1:0]                  rd_addr,
	output logic signed [pn_pkg::W_VAL-1:0] rd_data,
	output logic signed [pn_pkg::W_VAL-1:0] bias
);
	import pn_pkg::*;

	logic signed [W_VAL-1:0] mem_q [MAX_TAPS];
	logic [MAX_TAPS-1:0]     vld_q;
	logic signed [W_VAL-1:0] rd_data_q;
	logic                    rd_vld_q;
	logic signed [W_VAL-1:0] bias_q;
	logic [W_IDX+AW-1:0]     idx_ext;
	logic [AW-1:0]           wr_addr;
	logic                    wr_ok;

	// Indices beyond the store are dropped.
	assign idx_ext = {{AW{1'b0}}, wr_idx};
	assign wr_addr = idx_ext[AW-1:0];
	assign wr_ok   = wr_en && (idx_ext < (W_IDX+AW)'(MAX_TAPS));

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Entries never written read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			bias_q   <= '0;
		end else begin
			if (wr_ok) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
			if (wr_ok && (wr_idx == '0)) begin
				bias_q <= wr_data;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;
	assign bias    = bias_q;

endmodule

>>> hw/rtl/pn_mac.sv
// ---------------------------------------------------------------------------
// pn_mac
// Multiplier stage and accumulator; hands the vector sum on at the last sample.
// ---------------------------------------------------------------------------
module pn_mac (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pn_pkg::smp_ctl_t                ctl_s1,
	input  logic signed [pn_pkg::W_VAL-1:0] weight_s1,
	input  logic signed [pn_pkg::W_VAL-1:0] sample_s1,
	input  logic signed [pn_pkg::W_VAL-1:0] bias_s1,
	output logic                            vld_s3,
	output logic signed [pn_pkg::W_ACC-1:0] sum_s3,
	output logic signed [pn_pkg::W_VAL-1:0] bias_s3
);
	import pn_pkg::*;

	smp_ctl_t                 ctl_s2;
	logic signed [W_PROD-1:0] prod_s2;
	logic signed [W_VAL-1:0]  bias_s2;
	logic signed [W_ACC-1:0]  acc_q;
	logic signed [W_ACC-1:0]  addend;
	logic signed [W_ACC-1:0]  acc_next;

	always_ff @(posedge clk) begin
		prod_s2 <= weight_s1 * sample_s1;
		bias_s2 <= bias_s1;
		if (ctl_s2.vld && ctl_s2.last) begin
			sum_s3  <= acc_next;
			bias_s3 <= bias_s2;
		end
	end

	// Samples past the last weight contribute nothing.
	assign addend   = ctl_s2.en ? W_ACC'(prod_s2) : '0;
	assign acc_next = acc_q + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			acc_q  <= '0;
			vld_s3 <= 1'b0;
		end else begin
			ctl_s2 <= ctl_s1;
			vld_s3 <= ctl_s2.vld && ctl_s2.last;
			if (ctl_s2.vld) begin
				acc_q <= ctl_s2.last ? '0 : acc_next;
			end
		end
	end

endmodule

>>> hw/rtl/pn_act.sv
// ---------------------------------------------------------------------------
// pn_act
// Bias add, Q8.8 truncation with saturation, then the chosen activation.
// ---------------------------------------------------------------------------
module pn_act (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [pn_pkg::W_MODE-1:0]       mode,
	input  logic                            vld_s3,
	input  logic signed [pn_pkg::W_ACC-1:0] sum_s3,
	input  logic signed [pn_pkg::W_VAL-1:0] bias_s3,
	output logic                            res_vld,
	output pn_pkg::res_t                    res
);
	import pn_pkg::*;

	localparam logic signed [W_ACC-1:0] SUM_MAX = W_ACC'(2**(W_VAL-1) - 1);
	localparam logic signed [W_ACC-1:0] SUM_MIN = -W_ACC'(2**(W_VAL-1));
	localparam logic signed [W_VAL-1:0] ONE_Q88 = W_VAL'(2**FRAC_BITS);

	logic signed [W_ACC-1:0] total;
	logic signed [W_ACC-1:0] floored;
	logic                    vld_s4;
	logic signed [W_VAL-1:0] sum_s4;
	logic                    sat_s4;
	logic signed [W_VAL-5:0] q44;
	logic [7:0]              tab_idx;
	logic                    neg;
	logic [8:0]              sig;

	// Bias is Q8.8, the sum Q24.16; the arithmetic shift floors.
	assign total   = sum_s3 + (W_ACC'(bias_s3) <<< FRAC_BITS);
	assign floored = total >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			if (floored > SUM_MAX) begin
				sum_s4 <= SUM_MAX[W_VAL-1:0];
				sat_s4 <= 1'b1;
			end else if (floored < SUM_MIN) begin
				sum_s4 <= SUM_MIN[W_VAL-1:0];
				sat_s4 <= 1'b1;
			end else begin
				sum_s4 <= floored[W_VAL-1:0];
				sat_s4 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	// Sigmoid: Q4.4 argument clipped to one byte, the lower half mirrored.
	assign q44 = sum_s4[W_VAL-1:4];
	always_comb begin
		neg = q44[W_VAL-5];
		if (!neg && (q44 > 12'sd127)) begin
			tab_idx = 8'd127;
		end else if (neg && (q44 < -12'sd128)) begin
			tab_idx = 8'd128;
		end else if (neg) begin
			tab_idx = 8'(-q44);
		end else begin
			tab_idx = q44[7:0];
		end
		sig = neg ? (9'd256 - SIG_HALF[tab_idx]) : SIG_HALF[tab_idx];
	end

	always_comb begin
		res.sat = sat_s4;
		case (mode)
			MODE_STEP: begin
				res.act = sum_s4[W_VAL-1] ? '0 : ONE_Q88;
			end
			MODE_SIGMOID: begin
				res.act = W_VAL'(sig);
			end
			default: begin
				res.act = sum_s4;
			end
		endcase
	end

	assign res_vld = vld_s4;

endmodule

>>> hw/rtl/pn_ofifo.sv
// ---------------------------------------------------------------------------
// pn_ofifo
// Small result queue that decouples the pipeline from the output channel.
// ---------------------------------------------------------------------------
module pn_ofifo (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  pn_pkg::res_t wr_data,
	input  logic         rd_en,
	output logic         not_empty,
	output pn_pkg::res_t rd_data
);
	import pn_pkg::*;

	localparam int PW = $clog2(OFIFO_DEPTH);
	localparam int CW = $clog2(OFIFO_DEPTH + 1);

	res_t          buf_q [OFIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[wr_ptr_q] <= wr_data;
		end
	end

	// Space is guaranteed by the credit count upstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(wr_en) - CW'(rd_en);
		end
	end

	assign not_empty = (cnt_q != '0);
	assign rd_data   = buf_q[rd_ptr_q];

endmodule

>>> hw/rtl/perceptron_neuron.sv
// ---------------------------------------------------------------------------
// perceptron_neuron
// Single fixed-point neuron: weight store, multiply-accumulate, activation.
// ---------------------------------------------------------------------------
// Usage. Input beats on in_valid/in_ready either write a Q8.8 weight
// (opcode write, weight_index, value; entry 0 is the bias) or carry one Q8.8
// sample. Samples pair in order with weights 1, 2, 3 and so on; those beyond
// the last weight add nothing. A sample beat with last set closes the vector
// and yields one result beat on out_valid/out_ready: activation and the
// saturated flag. The cfg channel sets the activation mode and should only be
// written while no vector is in flight; cfg_ready is always high.
// Throughput is one input beat per cycle while in_ready is high. The result
// passes the memory read at the edge that accepts the last sample, then the
// multiplier, accumulator, bias and saturation, and activation into the
// result queue, which raises out_valid.
// The result queue holds eight beats and a credit counter reserves a slot for
// each accepted last sample, so a stalled receiver is absorbed there and
// in_ready only falls once eight results are pending.
// Reset clears the weights (held as valid bits, so no sweep is needed), the
// accumulator, the sample position, the queue and the mode.
// ---------------------------------------------------------------------------
module perceptron_neuron #(
	parameter int MAX_TAPS = pn_pkg::MAX_TAPS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pn_pkg::W_MODE-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            opcode,
	input  logic [pn_pkg::W_IDX-1:0]        weight_index,
	input  logic signed [pn_pkg::W_VAL-1:0] value,
	input  logic                            last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [pn_pkg::W_VAL-1:0] activation,
	output logic                            saturated
);
	import pn_pkg::*;

	localparam int AW = $clog2(MAX_TAPS);
	localparam int PW = $clog2(MAX_TAPS + 1);
	localparam int CW = $clog2(OFIFO_DEPTH + 1);

	logic [W_MODE-1:0]       mode_q;
	logic [PW-1:0]           pos_q;
	logic [CW-1:0]           credit_q;
	logic                    accept;
	logic                    smp;
	logic                    in_range;
	logic                    pop;
	smp_ctl_t                ctl_s1;
	logic signed [W_VAL-1:0] sample_s1;
	logic signed [W_VAL-1:0] bias_s1;
	logic signed [W_VAL-1:0] weight_s1;
	logic signed [W_VAL-1:0] bias_cur;
	logic                    vld_s3;
	logic signed [W_ACC-1:0] sum_s3;
	logic signed [W_VAL-1:0] bias_s3;
	logic                    res_vld;
	res_t                    res;
	res_t                    head;

	// Mode register; writes are only expected while the block is idle.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RAW;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	// A beat is taken while a queue slot can still be promised to it.
	assign in_ready = (credit_q < CW'(OFIFO_DEPTH));
	assign accept   = in_valid && in_ready;
	assign smp      = accept && (opcode == OP_SAMPLE);
	assign in_range = (pos_q < PW'(MAX_TAPS));
	assign pop      = out_valid && out_ready;

	// The credit counter tracks vectors closed but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + CW'(smp && last) - CW'(pop);
		end
	end

	// Sample position starts at one, skipping the bias, and stops at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= PW'(1);
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld  <= smp;
			ctl_s1.en   <= in_range;
			ctl_s1.last <= last;
			if (smp) begin
				if (last) begin
					pos_q <= PW'(1);
				end else if (in_range) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	// Sample and bias are captured alongside the weight read.
	always_ff @(posedge clk) begin
		if (smp) begin
			sample_s1 <= value;
			bias_s1   <= bias_cur;
		end
	end

	pn_wstore #(
		.MAX_TAPS(MAX_TAPS),
		.AW      (AW)
	) u_wstore (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept && (opcode == OP_WRITE)),
		.wr_idx (weight_index),
		.wr_data(value),
		.rd_en  (smp && in_range),
		.rd_addr(pos_q[AW-1:0]),
		.rd_data(weight_s1),
		.bias   (bias_cur)
	);

	pn_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.weight_s1(weight_s1),
		.sample_s1(sample_s1),
		.bias_s1  (bias_s1),
		.vld_s3   (vld_s3),
		.sum_s3   (sum_s3),
		.bias_s3  (bias_s3)
	);

	pn_act u_act (
		.clk    (clk),
		.arst_n (arst_n),
		.mode   (mode_q),
		.vld_s3 (vld_s3),
		.sum_s3 (sum_s3),
		.bias_s3(bias_s3),
		.res_vld(res_vld),
		.res    (res)
	);

	pn_ofifo u_ofifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (res_vld),
		.wr_data  (res),
		.rd_en    (pop),
		.not_empty(out_valid),
		.rd_data  (head)
	);

	assign activation = head.act;
	assign saturated  = head.sat;

endmodule
